FILE: rtl/core/stq_pkg.sv
// Shared types and constants of the sorted timer queue.
package stq_pkg;
  localparam int NumTimers = 16;
  localparam int IdW = 4;
  localparam int PosW = 4;
  localparam int CntW = 5;

  localparam logic [2:0] ActTick = 3'd0;
  localparam logic [2:0] ActStartAbs = 3'd1;
  localparam logic [2:0] ActStartRel = 3'd2;
  localparam logic [2:0] ActStop = 3'd3;
  localparam logic [2:0] ActRead = 3'd4;

  localparam logic KindStatus = 1'b0;
  localparam logic KindExpired = 1'b1;

  typedef enum logic [3:0] {
    StIdle,
    StScan,
    StScanWait,
    StShiftUp,
    StShiftUpWait,
    StRemove,
    StRemoveWait,
    StSweepRd,
    StSweepWait,
    StSweepChk
  } state_t;

  typedef struct packed {
    logic [31:0] expiry;
    logic [IdW-1:0] slot;
  } entry_t;

  // Wraparound ordering: a is before b when bit 31 of a - b is set.
  function automatic logic is_before(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction
endpackage

FILE: rtl/core/stq_ram.sv
// Single-port-write, single-port-read table with registered read data.
module stq_ram import stq_pkg::*; (
  input  logic            clk,
  input  logic            we,
  input  logic [PosW-1:0] waddr,
  input  entry_t          wdata,
  input  logic [PosW-1:0] raddr,
  output entry_t          rdata
);
  entry_t mem [NumTimers];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/core/sorted_timer_queue.sv
// Sorted timer queue: a 32-bit tick counter and sixteen timers held in one
// table ordered by expiry (wraparound compare, equal expiries in arrival order).
// One transaction is handled at a time. Each walks the table: an insert scans
// to its position and shifts the tail up, a stop scans and shifts the tail down,
// and each expired head costs a shift of the remaining entries plus a read
// and check of the new head (StSweepRd, StSweepWait, StSweepChk), all through
// the table's single, registered read port. One status result comes out first,
// then one result per expired timer. Each result is presented only after the
// next head has been checked, so last is known when it appears. A stalled
// output holds the walk at the next result until it is taken.
module sorted_timer_queue import stq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  action,
  input  logic [3:0]  timer_id,
  input  logic [31:0] time_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [3:0]  expired_id,
  output logic        status,
  output logic [31:0] time_now,
  output logic        last
);
  state_t state, state_next;

  logic [31:0]    current_time, current_time_next;
  logic [CntW-1:0] pending_count, pending_count_next;
  logic [NumTimers-1:0] slot_active, slot_active_next;

  logic [2:0]     act;
  logic [IdW-1:0] id;
  logic [31:0]    expiry;
  logic           st;
  logic [CntW-1:0] pos, pos_next;
  logic [CntW-1:0] ptr, ptr_next;
  logic           act_next_ld;
  logic           st_next;
  logic           pend_kind, pend_kind_next;

  logic           we;
  logic [PosW-1:0] waddr, raddr;
  entry_t         wdata, rdata;

  logic           o_load;
  logic           o_kind, o_status, o_last;
  logic [IdW-1:0] o_id;

  stq_ram u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic out_free;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != StIdle);

  // Sweep decision: is the head due.
  logic head_due;
  assign head_due = (pending_count != '0) && !is_before(current_time, rdata.expiry);

  always_comb begin
    state_next = state;
    current_time_next = current_time;
    pending_count_next = pending_count;
    slot_active_next = slot_active;
    pos_next = pos;
    ptr_next = ptr;
    st_next = st;
    pend_kind_next = pend_kind;
    act_next_ld = 1'b0;
    we = 1'b0;
    waddr = ptr[PosW-1:0];
    wdata = rdata;
    raddr = ptr[PosW-1:0];
    o_load = 1'b0;
    o_kind = KindStatus;
    o_status = st;
    o_id = id;
    o_last = 1'b0;
    unique case (state)
      StIdle: begin
        if (in_valid) begin
          act_next_ld = 1'b1;
          pos_next = '0;
          ptr_next = '0;
          st_next = 1'b0;
          pend_kind_next = KindStatus;
          state_next = StSweepRd;
          unique case (action)
            ActTick: current_time_next = current_time + 32'd1;
            ActStartAbs, ActStartRel: begin
              if (slot_active[timer_id] ||
                  (action == ActStartRel && time_value == '0)) begin
                st_next = 1'b1;
              end else begin
                state_next = StScan;
              end
            end
            ActStop: begin
              if (slot_active[timer_id]) begin
                state_next = StScan;
              end
            end
            ActRead: ;
            default: st_next = 1'b1;
          endcase
        end
      end
      StScan: begin
        // Read entry at pos.
        raddr = pos[PosW-1:0];
        if (pos == pending_count) begin
          if (act == ActStop) begin
            state_next = StSweepRd;
          end else begin
            ptr_next = pending_count;
            state_next = StShiftUp;
          end
        end else begin
          state_next = StScanWait;
        end
      end
      StScanWait: begin
        raddr = pos[PosW-1:0];
        if (act == ActStop) begin
          if (rdata.slot == id) begin
            ptr_next = pos;
            state_next = StRemove;
          end else begin
            pos_next = pos + 1'b1;
            state_next = StScan;
          end
        end else if (is_before(expiry, rdata.expiry)) begin
          ptr_next = pending_count;
          state_next = StShiftUp;
        end else begin
          pos_next = pos + 1'b1;
          state_next = StScan;
        end
      end
      StShiftUp: begin
        // Move entry ptr-1 to ptr, down to pos; then write the new entry.
        if (ptr == pos) begin
          we = 1'b1;
          waddr = pos[PosW-1:0];
          wdata.expiry = expiry;
          wdata.slot = id;
          pending_count_next = pending_count + 1'b1;
          slot_active_next[id] = 1'b1;
          state_next = StSweepRd;
        end else begin
          raddr = ptr[PosW-1:0] - 1'b1;
          state_next = StShiftUpWait;
        end
      end
      StShiftUpWait: begin
        we = 1'b1;
        waddr = ptr[PosW-1:0];
        ptr_next = ptr - 1'b1;
        state_next = StShiftUp;
      end
      StRemove: begin
        // Move entry ptr+1 to ptr until the tail.
        if (ptr + 1'b1 >= pending_count) begin
          pending_count_next = pending_count - 1'b1;
          if (act == ActStop && pend_kind == KindStatus) begin
            slot_active_next[id] = 1'b0;
          end
          state_next = StSweepRd;
        end else begin
          raddr = ptr[PosW-1:0] + 1'b1;
          state_next = StRemoveWait;
        end
      end
      StRemoveWait: begin
        we = 1'b1;
        waddr = ptr[PosW-1:0];
        ptr_next = ptr + 1'b1;
        state_next = StRemove;
      end
      StSweepRd: begin
        raddr = '0;
        state_next = StSweepWait;
      end
      StSweepWait: begin
        raddr = '0;
        state_next = StSweepChk;
      end
      StSweepChk: begin
        // The waiting result goes out once the head check says whether more follow.
        raddr = '0;
        if (out_free) begin
          o_load = 1'b1;
          o_kind = pend_kind;
          o_id = (pend_kind == KindExpired) ? pos[IdW-1:0] : id;
          o_status = (pend_kind == KindExpired) ? 1'b0 : st;
          o_last = !head_due;
          if (head_due) begin
            ptr_next = '0;
            slot_active_next[rdata.slot] = 1'b0;
            pos_next = {1'b0, rdata.slot};
            pend_kind_next = KindExpired;
            state_next = StRemove;
          end else begin
            state_next = StIdle;
          end
        end
      end
      default: state_next = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      current_time <= '0;
      pending_count <= '0;
      slot_active <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      current_time <= current_time_next;
      pending_count <= pending_count_next;
      slot_active <= slot_active_next;
      if (o_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (act_next_ld) begin
      act <= action;
      id <= timer_id;
      expiry <= (action == ActStartRel) ? current_time + time_value : time_value;
    end
    st <= st_next;
    pos <= pos_next;
    ptr <= ptr_next;
    pend_kind <= pend_kind_next;
    if (o_load) begin
      kind <= o_kind;
      status <= o_status;
      expired_id <= o_id;
      time_now <= current_time;
      last <= o_last;
    end
  end
endmodule

FILE: rtl/core/stq_checker.sv
// Port-level checker for the sorted timer queue, bound to the top level.
module stq_checker import stq_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        kind,
  input logic [3:0]  expired_id,
  input logic        status,
  input logic [31:0] time_now,
  input logic        last
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(time_now) && $stable(last))
    else $error("stalled result changed");
  a_out_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(kind) && $stable(expired_id) && $stable(status))
    else $error("stalled result fields changed");
  a_exp_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KindExpired |-> status == 1'b0)
    else $error("expiry result with nonzero status");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> in_stall)
    else $error("input taken while results pending");
  a_taken_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("block not busy after taking a transaction");
endmodule

bind sorted_timer_queue stq_checker u_stq_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .kind(kind),
  .expired_id(expired_id), .status(status), .time_now(time_now), .last(last)
);

FILE: bench/sorted_timer_queue_tb.sv
// Self-checking testbench of the sorted timer queue with a scoreboard class.
`timescale 1ns / 100ps

class timer_queue_scoreboard;
  typedef struct {
    logic        kind;
    logic [3:0]  id;
    logic        status;
    logic [31:0] now;
    logic        last;
  } timer_result_t;

  logic [31:0] now_ticks;
  logic [31:0] expiry_tab[16];
  logic [3:0]  slot_tab[16];
  int          entry_count;
  bit          armed[16];
  timer_result_t expected_results[$];
  int          errors;
  int          seen_results;
  int          seen_expiries;

  function new();
    now_ticks = 0;
    entry_count = 0;
    errors = 0;
    seen_results = 0;
    seen_expiries = 0;
    foreach (armed[i]) armed[i] = 0;
  endfunction

  function bit earlier(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

  function void push_result(logic kind, logic [3:0] id, logic status);
    timer_result_t r;
    r.kind = kind;
    r.id = id;
    r.status = status;
    r.now = now_ticks;
    r.last = 0;
    expected_results.push_back(r);
  endfunction

  function void drop_entry(int pos);
    for (int k = pos; k + 1 < entry_count; k++) begin
      expiry_tab[k] = expiry_tab[k + 1];
      slot_tab[k] = slot_tab[k + 1];
    end
    entry_count--;
  endfunction

  function logic arm_timer(logic [3:0] id, logic [31:0] expiry);
    int pos;
    if (armed[id]) return 1'b1;
    pos = 0;
    while (pos < entry_count && !earlier(expiry, expiry_tab[pos])) pos++;
    for (int k = entry_count; k > pos; k--) begin
      expiry_tab[k] = expiry_tab[k - 1];
      slot_tab[k] = slot_tab[k - 1];
    end
    expiry_tab[pos] = expiry;
    slot_tab[pos] = id;
    entry_count++;
    armed[id] = 1;
    return 1'b0;
  endfunction

  // Applies one accepted transaction and queues the results it causes.
  function void note_input(logic [2:0] action, logic [3:0] id, logic [31:0] tv);
    logic st;
    logic [3:0] sid;
    st = 0;
    case (action)
      stq_pkg::ActTick: now_ticks = now_ticks + 1;
      stq_pkg::ActStartAbs: st = arm_timer(id, tv);
      stq_pkg::ActStartRel: st = (tv == 0) ? 1'b1 : arm_timer(id, now_ticks + tv);
      stq_pkg::ActStop: begin
        if (armed[id]) begin
          for (int k = 0; k < entry_count; k++) begin
            if (slot_tab[k] == id) begin
              drop_entry(k);
              break;
            end
          end
          armed[id] = 0;
        end
      end
      stq_pkg::ActRead: ;
      default: st = 1;
    endcase
    push_result(stq_pkg::KindStatus, id, st);
    while (entry_count > 0 && !earlier(now_ticks, expiry_tab[0])) begin
      sid = slot_tab[0];
      drop_entry(0);
      armed[sid] = 0;
      push_result(stq_pkg::KindExpired, sid, 1'b0);
    end
    expected_results[expected_results.size() - 1].last = 1;
  endfunction

  task report(string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  task check_result(logic kind, logic [3:0] id, logic status,
                    logic [31:0] now, logic last);
    timer_result_t e;
    seen_results++;
    if (kind === stq_pkg::KindExpired) seen_expiries++;
    if (expected_results.size() == 0) begin
      report($sformatf("unexpected result kind=%0d id=%0d", kind, id));
      return;
    end
    e = expected_results.pop_front();
    if (kind !== e.kind) report($sformatf("kind %0d, want %0d", kind, e.kind));
    if (id !== e.id) report($sformatf("expired_id %0d, want %0d", id, e.id));
    if (status !== e.status) report($sformatf("status %0d, want %0d", status, e.status));
    if (now !== e.now) report($sformatf("time_now %h, want %h", now, e.now));
    if (last !== e.last) report($sformatf("last %0d, want %0d", last, e.last));
  endtask
endclass

module sorted_timer_queue_tb;
  import stq_pkg::*;

  localparam int CycleLimit = 400000;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic [2:0]  action = ActTick;
  logic [3:0]  timer_id = 0;
  logic [31:0] time_value = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic        kind;
  logic [3:0]  expired_id;
  logic        status;
  logic [31:0] time_now;
  logic        last;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycles = 0;
  int sent = 0;

  timer_queue_scoreboard timers = new();

  sorted_timer_queue uut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("sorted_timer_queue regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      timers.check_result(kind, expired_id, status, time_now, last);
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Valid stays high after a transaction is taken until the next call decides.
  task automatic send(logic [2:0] a, logic [3:0] id, logic [31:0] tv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    action <= a;
    timer_id <= id;
    time_value <= tv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    timers.note_input(a, id, tv);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (timers.expected_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic send_random();
    int r;
    logic [31:0] tv;
    r = $urandom_range(99);
    case ($urandom_range(3))
      0: tv = $urandom_range(40);
      1: tv = timers.now_ticks + $urandom_range(20) - 5;
      2: tv = $urandom;
      default: tv = {$urandom_range(1) == 1, 31'd0} | 32'($urandom_range(3));
    endcase
    if (r < 35) send(ActTick, 4'($urandom), $urandom);
    else if (r < 50) send(ActStartRel, 4'($urandom), tv);
    else if (r < 65) send(ActStartAbs, 4'($urandom), tv);
    else if (r < 85) send(ActStop, 4'($urandom), $urandom);
    else if (r < 95) send(ActRead, 4'($urandom), $urandom);
    else send(3'($urandom_range(7, 5)), 4'($urandom), $urandom);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed: rejections, equal expiries, past expiry, stop cases, wrap.
    send(ActRead, 4'hF, 32'hFFFFFFFF);
    send(ActStartRel, 4'd0, 32'd0);
    send(ActStartRel, 4'd1, 32'd3);
    send(ActStartRel, 4'd1, 32'd5);
    send(ActStartAbs, 4'd2, 32'd3);
    send(ActStartAbs, 4'd3, 32'd3);
    send(ActStop, 4'd2, 32'd0);
    send(ActStop, 4'd2, 32'd0);
    send(ActStartAbs, 4'd15, 32'hFFFFFFFF);
    send(ActTick, 4'd0, 32'd0);
    send(ActTick, 4'd0, 32'd0);
    send(ActTick, 4'd0, 32'd0);
    send(ActStartAbs, 4'd4, 32'd0);
    send(ActStartRel, 4'd5, 32'h7FFFFFFF);
    send(ActStartRel, 4'd6, 32'h80000000);
    send(3'd5, 4'd7, 32'd0);
    send(3'd7, 4'd7, 32'd0);
    for (int i = 0; i < 16; i++) send(ActStartRel, 4'(i), 32'd2);
    send(ActTick, 4'd0, 32'd0);
    send(ActTick, 4'd0, 32'd0);
    drain();
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 36 : (ph == 1) ? 88 : 0;
      recv_idle_pct = (ph == 0) ? 88 : (ph == 1) ? 36 : 0;
      for (int i = 0; i < 40; i++) send_random();
      drain();
    end
    $display("sent %0d transactions, checked %0d results (%0d expiries)",
             sent, timers.seen_results, timers.seen_expiries);
    if (timers.errors == 0 && timers.expected_results.size() == 0)
      $display("sorted_timer_queue regression: pass");
    else
      $display("sorted_timer_queue regression: fail");
    $finish;
  end
endmodule
